// ===== rtl/core/atd_pkg.sv =====
// Package for the atan2 tenth-degree pipeline: widths, fixed-point constants
// and the control word that travels with each request. No dependencies.
package atd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int MAG_W     = COORD_W + 1;
    localparam int Z_W       = FRAC_BITS + 1;
    localparam int SQF_W     = 2 * Z_W;
    localparam int KS_W      = FRAC_BITS + 3;
    localparam int DEN_W     = KS_W + 7;
    localparam int GAIN_W    = 18;
    localparam int NUM_W     = Z_W + GAIN_W;
    localparam int CORE_W    = 9;
    localparam int ANG_W     = 12;

    localparam longint unsigned K_Q_L =
        ((64'd35714 << FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [KS_W-1:0]   K_Q      = KS_W'(K_Q_L);
    localparam logic [GAIN_W-1:0] GAIN_NUM = GAIN_W'(204643);
    localparam logic [6:0]        GAIN_DEN = 7'd100;

    localparam logic signed [ANG_W-1:0] ANG_HALF  = ANG_W'(1800);
    localparam logic signed [ANG_W-1:0] ANG_RIGHT = ANG_W'(900);

    typedef struct packed {
        logic valid;
        logic zero;
        logic flat;
        logic neg;
        logic x_neg;
        logic y_neg;
    } ctl_t;

endpackage

// ===== rtl/core/atd_front.sv =====
// Input stage: exact magnitudes, octant sort and sign bookkeeping.
// Depends on atd_pkg.
module atd_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [atd_pkg::COORD_W-1:0] y_coord,
    input  logic [atd_pkg::COORD_W-1:0] x_coord,
    output atd_pkg::ctl_t               ctl,
    output logic [atd_pkg::MAG_W-1:0]   num_mag,
    output logic [atd_pkg::MAG_W-1:0]   den_mag
);
    import atd_pkg::*;

    logic [MAG_W-1:0] y_ext, x_ext, y_mag, x_mag;
    ctl_t             ctl_reg, ctl_next;
    logic [MAG_W-1:0] num_reg, num_next, den_reg, den_next;

    always_comb begin
        y_ext = {y_coord[COORD_W-1], y_coord};
        x_ext = {x_coord[COORD_W-1], x_coord};
        y_mag = y_coord[COORD_W-1] ? (~y_ext + 1'b1) : y_ext;
        x_mag = x_coord[COORD_W-1] ? (~x_ext + 1'b1) : x_ext;
        ctl_next.valid = in_valid;
        ctl_next.zero  = (y_coord == '0) && (x_coord == '0);
        ctl_next.flat  = y_mag < x_mag;
        ctl_next.x_neg = x_coord[COORD_W-1];
        ctl_next.y_neg = y_coord[COORD_W-1];
        ctl_next.neg   = x_coord[COORD_W-1] ^ y_coord[COORD_W-1];
        num_next = ctl_next.flat ? y_mag : x_mag;
        den_next = ctl_next.flat ? x_mag : y_mag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_next;
        end
        if (en) begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    assign ctl     = ctl_reg;
    assign num_mag = num_reg;
    assign den_mag = den_reg;

endmodule

// ===== rtl/core/atd_ratio.sv =====
// Pipelined restoring divider for the ratio |num| * 2^FRAC_BITS / |den|,
// one quotient bit per stage. Depends on atd_pkg.
module atd_ratio (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  atd_pkg::ctl_t             ctl_in,
    input  logic [atd_pkg::MAG_W-1:0] num_mag,
    input  logic [atd_pkg::MAG_W-1:0] den_mag,
    output atd_pkg::ctl_t             ctl_out,
    output logic [atd_pkg::Z_W-1:0]   z_mag
);
    import atd_pkg::*;

    ctl_t             ctl_reg [0:Z_W];
    logic [MAG_W-1:0] rem_reg [0:Z_W];
    logic [MAG_W-1:0] den_reg [0:Z_W];
    logic [Z_W-1:0]   quo_reg [0:Z_W];

    always_comb begin
        ctl_reg[0] = ctl_in;
        rem_reg[0] = num_mag;
        den_reg[0] = den_mag;
        quo_reg[0] = '0;
    end

    for (genvar k = 0; k < Z_W; k++) begin : g_step
        logic [MAG_W:0]   trial;
        logic             take;
        logic [MAG_W-1:0] rem_next;
        logic [Z_W-1:0]   quo_next;

        always_comb begin
            trial    = (k == 0) ? {1'b0, rem_reg[k]} : {rem_reg[k], 1'b0};
            take     = trial >= {1'b0, den_reg[k]};
            rem_next = take ? MAG_W'(trial - {1'b0, den_reg[k]}) : MAG_W'(trial);
            quo_next = {quo_reg[k][Z_W-2:0], take};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[k+1] <= '0;
            end else if (en) begin
                ctl_reg[k+1] <= ctl_reg[k];
            end
            if (en) begin
                rem_reg[k+1] <= rem_next;
                den_reg[k+1] <= den_reg[k];
                quo_reg[k+1] <= quo_next;
            end
        end
    end

    assign ctl_out = ctl_reg[Z_W];
    assign z_mag   = quo_reg[Z_W];

endmodule

// ===== rtl/core/atd_core.sv =====
// Rational core 204643*z / (100*(K+z*z)): two multiply stages and a pipelined
// divider with one quotient bit per stage. Depends on atd_pkg.
module atd_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  atd_pkg::ctl_t             ctl_in,
    input  logic [atd_pkg::Z_W-1:0]   z_mag,
    output atd_pkg::ctl_t             ctl_out,
    output logic [atd_pkg::CORE_W-1:0] core
);
    import atd_pkg::*;

    ctl_t             ctl_a_reg, ctl_a_next, ctl_b_reg;
    logic [SQF_W-1:0] sq_a_reg;
    logic [NUM_W-1:0] num_a_reg, num_b_reg;
    logic [DEN_W-1:0] den_b_reg;
    logic [KS_W-1:0]  ks;

    ctl_t              ctl_reg [0:CORE_W];
    logic [NUM_W-1:0]  rem_reg [0:CORE_W];
    logic [DEN_W-1:0]  den_reg [0:CORE_W];
    logic [CORE_W-1:0] quo_reg [0:CORE_W];

    always_comb begin
        ctl_a_next     = ctl_in;
        ctl_a_next.neg = ctl_in.neg && (z_mag != '0);
        ks = K_Q + KS_W'(sq_a_reg[FRAC_BITS +: Z_W]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end else if (en) begin
            ctl_a_reg <= ctl_a_next;
            ctl_b_reg <= ctl_a_reg;
        end
        if (en) begin
            sq_a_reg  <= z_mag * z_mag;
            num_a_reg <= GAIN_NUM * z_mag;
            num_b_reg <= num_a_reg;
            den_b_reg <= ks * GAIN_DEN;
        end
    end

    always_comb begin
        ctl_reg[0] = ctl_b_reg;
        rem_reg[0] = num_b_reg;
        den_reg[0] = den_b_reg;
        quo_reg[0] = '0;
    end

    for (genvar j = 0; j < CORE_W; j++) begin : g_step
        logic [NUM_W-1:0]  shifted;
        logic              take;
        logic [NUM_W-1:0]  rem_next;
        logic [CORE_W-1:0] quo_next;

        always_comb begin
            shifted  = NUM_W'(den_reg[j]) << (CORE_W - 1 - j);
            take     = rem_reg[j] >= shifted;
            rem_next = take ? (rem_reg[j] - shifted) : rem_reg[j];
            quo_next = {quo_reg[j][CORE_W-2:0], take};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[j+1] <= '0;
            end else if (en) begin
                ctl_reg[j+1] <= ctl_reg[j];
            end
            if (en) begin
                rem_reg[j+1] <= rem_next;
                den_reg[j+1] <= den_reg[j];
                quo_reg[j+1] <= quo_next;
            end
        end
    end

    assign ctl_out = ctl_reg[CORE_W];
    assign core    = quo_reg[CORE_W];

endmodule

// ===== rtl/core/atan2_tenth_degree_approx.sv =====
// Channel  Ports                                   Contents
// s_       s_tvalid s_tready s_tdata[63:0]         y_coord, x_coord
// m_       m_tvalid m_tready m_tdata[15:0] m_tuser angle_tenths, both_zero
//
// One request enters per cycle unless the output stalls, and passes FRAC_BITS + 14
// register stages: the front, FRAC_BITS + 1 ratio quotient bits, two multiply stages,
// nine core quotient bits and the output register.
// Reset clears every valid bit; payload registers are not reset.
// A result held at the output stalls the whole pipeline, so nothing is lost.
// Depends on atd_pkg, atd_front, atd_ratio and atd_core.
module atan2_tenth_degree_approx (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // y_coord[31:0], x_coord[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // angle_tenths[11:0], zero fill[15:12]
    output logic        m_tuser    // both_zero[0]
);
    import atd_pkg::*;

    logic              en;
    ctl_t              ctl_f, ctl_r, ctl_c;
    logic [MAG_W-1:0]  num_mag, den_mag;
    logic [Z_W-1:0]    z_mag;
    logic [CORE_W-1:0] core;

    logic                    valid_reg;
    logic signed [ANG_W-1:0] ang_reg, ang_next, signed_core, base;
    logic                    zero_reg;

    assign en       = m_tready || !valid_reg;
    assign s_tready = en;

    atd_front u_front (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_tvalid),
        .y_coord(s_tdata[31:0]), .x_coord(s_tdata[63:32]),
        .ctl(ctl_f), .num_mag(num_mag), .den_mag(den_mag)
    );

    atd_ratio u_ratio (
        .aclk(aclk), .aresetn(aresetn), .en(en), .ctl_in(ctl_f),
        .num_mag(num_mag), .den_mag(den_mag), .ctl_out(ctl_r), .z_mag(z_mag)
    );

    atd_core u_core (
        .aclk(aclk), .aresetn(aresetn), .en(en), .ctl_in(ctl_r),
        .z_mag(z_mag), .ctl_out(ctl_c), .core(core)
    );

    always_comb begin
        signed_core = ANG_W'(core);
        if (ctl_c.neg) begin
            signed_core = -signed_core;
        end
        if (ctl_c.flat) begin
            base = signed_core;
            if (ctl_c.x_neg) begin
                base = ctl_c.y_neg ? (signed_core - ANG_HALF) : (signed_core + ANG_HALF);
            end
        end else begin
            base = ANG_RIGHT - signed_core;
            if (ctl_c.y_neg) begin
                base = base - ANG_HALF;
            end
        end
        ang_next = ctl_c.zero ? '0 : base;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctl_c.valid;
        end
        if (en) begin
            ang_reg  <= ang_next;
            zero_reg <= ctl_c.zero;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0000, ang_reg};
    assign m_tuser  = zero_reg;

endmodule
